// ===== sv/ols_pkg.sv =====
// Shared types and constants of the ordered list store.
package ols_pkg;

	// Operation codes carried in the input word's tuser.
	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_REMOVE     = 2'd1,
		OP_SEARCH     = 2'd2,
		OP_SEARCH_ALL = 2'd3
	} ols_op_t;

	// Result status codes carried in the output word's tuser.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} ols_status_t;

	// Sequencer states.
	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} ols_state_t;

	// Most results that one search-all word may produce.
	localparam int MaxResults = 16;

	// Control bundle from the sequencer to one cell.
	typedef struct packed {
		logic live;   // cell index is below the current count
		logic load;   // capture the compare result against the key
		logic shift;  // take the match flag of the next cell
		logic write;  // store the key as this cell's entry
		logic close;  // take the entry of the next cell (gap closing)
	} ols_cell_ctrl_t;

endpackage

// ===== sv/ols_cell.sv =====
// One storage cell of the list: an entry register and its match flag.
module ols_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ols_pkg::ols_cell_ctrl_t ctrl,
	input  logic signed [31:0]    key,
	input  logic signed [31:0]    next_entry,
	input  logic                  next_match,
	output logic signed [31:0]    entry,
	output logic                  match
);

	logic signed [31:0] entry_q;
	logic               match_q;

	always_ff @(posedge clk) begin
		if (ctrl.write) begin
			entry_q <= key;
		end else if (ctrl.close) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.load) begin
			match_q <= ctrl.live && (entry_q == key);
		end else if (ctrl.shift) begin
			match_q <= next_match;
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// ===== sv/ordered_list_store_core.sv =====
// Results: insert, and remove on an empty list, give a result word in the cycle after acceptance;
// other words scan one index per cycle while the output register is free; the scan ends at the count,
// a search stops at its first match and a remove closes its gap on the edge of its result.
// Input: an insert every cycle while the output is free; no new word is taken during a scan.
// Reset: arst_n clears the count, the sequencer and the output valid; the entries are not
// cleared and are only read below the count.
module ordered_list_store_core #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] position, [8:4] entry_count, [15:9] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	localparam int CntW  = $clog2(CAPACITY + 1);
	localparam int NresW = $clog2(ols_pkg::MaxResults + 1);

	// Sequencer registers.
	ols_pkg::ols_state_t state_q, state_d;
	ols_pkg::ols_op_t    op_q;
	logic [CntW-1:0]     count_q, count_d;
	logic [CntW-1:0]     k_q;      // index currently presented by cell zero
	logic [CntW-1:0]     pos_q;    // latest match seen during the scan
	logic                hit_q;    // a match has been seen (for search-all: one is pending)
	logic [NresW-1:0]    nres_q;   // search-all matches counted so far

	// Output register.
	logic                  m_tvalid_q;
	ols_pkg::ols_status_t  m_status_q;
	logic [3:0]            m_pos_q;
	logic                  m_last_q;
	logic [4:0]            m_cnt_q;

	// Input word decode.
	ols_pkg::ols_op_t   in_op;
	logic signed [31:0] in_value;
	logic               in_acc;
	logic               slot_free;
	logic               full;

	// Scan control.
	logic scan_live, more, step, finish, m0, wr_ins, close_en;

	// Result word being formed this cycle.
	logic                 emit;
	ols_pkg::ols_status_t e_status;
	logic [CntW-1:0]      e_pos;
	logic                 e_last;

	// Cell chain wiring.
	ols_pkg::ols_cell_ctrl_t ctrl    [CAPACITY];
	logic signed [31:0]      entry_w [CAPACITY];
	logic                    match_w [CAPACITY];

	assign in_op     = ols_pkg::ols_op_t'(s_tuser);
	assign in_value  = s_tdata;
	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ols_pkg::S_IDLE) && slot_free;
	assign in_acc    = s_tvalid && s_tready;
	assign full      = (count_q == CntW'(CAPACITY));

	// The scan walks k from zero up to the count; search-all also stops once the result cap is hit.
	assign scan_live = (state_q == ols_pkg::S_SCAN) && slot_free;
	assign more      = (k_q < count_q) &&
		!((op_q == ols_pkg::OP_SEARCH_ALL) && (nres_q == NresW'(ols_pkg::MaxResults)));
	assign step      = scan_live && more;
	assign finish    = scan_live && !more;
	assign m0        = match_w[0];

	assign wr_ins   = in_acc && (in_op == ols_pkg::OP_INSERT) && !full;
	assign close_en = finish && (op_q == ols_pkg::OP_REMOVE) && hit_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ols_pkg::S_IDLE: begin
				if (in_acc && (in_op != ols_pkg::OP_INSERT) &&
					!((in_op == ols_pkg::OP_REMOVE) && (count_q == '0))) begin
					state_d = ols_pkg::S_SCAN;
				end
			end
			ols_pkg::S_SCAN: begin
				if (finish || (step && m0 && (op_q == ols_pkg::OP_SEARCH))) begin
					state_d = ols_pkg::S_IDLE;
				end
			end
			default: state_d = ols_pkg::S_IDLE;
		endcase
	end

	// Result formation and count update.
	always_comb begin
		emit     = 1'b0;
		e_status = ols_pkg::ST_OK;
		e_pos    = '0;
		e_last   = 1'b1;
		count_d  = count_q;
		case (state_q)
			ols_pkg::S_IDLE: begin
				if (in_acc && (in_op == ols_pkg::OP_INSERT)) begin
					emit = 1'b1;
					if (full) begin
						e_status = ols_pkg::ST_FULL;
					end else begin
						count_d = count_q + 1'b1;
					end
				end else if (in_acc && (in_op == ols_pkg::OP_REMOVE) && (count_q == '0)) begin
					emit     = 1'b1;
					e_status = ols_pkg::ST_EMPTY;
				end
			end
			ols_pkg::S_SCAN: begin
				if (step && m0) begin
					if (op_q == ols_pkg::OP_SEARCH) begin
						emit  = 1'b1;
						e_pos = k_q;
					end else if ((op_q == ols_pkg::OP_SEARCH_ALL) && hit_q) begin
						// A later match exists, so the pending one is not the final word.
						emit   = 1'b1;
						e_pos  = pos_q;
						e_last = 1'b0;
					end
				end else if (finish) begin
					emit = 1'b1;
					if ((op_q != ols_pkg::OP_SEARCH) && hit_q) begin
						e_pos = pos_q;
						if (op_q == ols_pkg::OP_REMOVE) begin
							count_d = count_q - 1'b1;
						end
					end else begin
						e_status = ols_pkg::ST_NOT_FOUND;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ols_pkg::S_IDLE;
			op_q    <= ols_pkg::OP_INSERT;
			count_q <= '0;
			k_q     <= '0;
			pos_q   <= '0;
			hit_q   <= 1'b0;
			nres_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (in_acc) begin
				op_q   <= in_op;
				k_q    <= '0;
				hit_q  <= 1'b0;
				nres_q <= '0;
			end else if (step) begin
				k_q <= k_q + 1'b1;
				if (m0) begin
					hit_q  <= 1'b1;
					pos_q  <= k_q;
					nres_q <= nres_q + 1'b1;
				end
			end
		end
	end

	// Output register: takes a new word whenever the previous one has gone or is going.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_status_q <= e_status;
			m_pos_q    <= 4'(e_pos);
			m_last_q   <= e_last;
			m_cnt_q    <= 5'(count_d);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {7'd0, m_cnt_q, m_pos_q};

	// The chain: every cell compares against the key when a word is accepted, then the match
	// flags move one cell towards the head per scan step. On a remove, the cells from the
	// removed position onwards all take their successor's entry in the same cycle.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] nxt_entry;
		logic               nxt_match;

		if (i == CAPACITY - 1) begin : g_tail
			assign nxt_entry = entry_w[i];
			assign nxt_match = 1'b0;
		end else begin : g_body
			assign nxt_entry = entry_w[i+1];
			assign nxt_match = match_w[i+1];
		end

		assign ctrl[i].live  = (CntW'(i) < count_q);
		assign ctrl[i].load  = in_acc;
		assign ctrl[i].shift = step;
		assign ctrl[i].write = wr_ins && (count_q == CntW'(i));
		assign ctrl[i].close = close_en && (CntW'(i) >= pos_q);

		ols_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl[i]),
			.key        (in_value),
			.next_entry (nxt_entry),
			.next_match (nxt_match),
			.entry      (entry_w[i]),
			.match      (match_w[i])
		);
	end

endmodule

// ===== sv/ols_checker.sv =====
// Port-level checks of the ordered list store, bound to its top level.
module ols_checker #(
	parameter int CAPACITY = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A word that is not a success is always the only and final word, at position zero.
	a_fail_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ols_pkg::ST_OK) |-> m_tlast && (m_tdata[3:0] == 4'd0))
		else $error("failure word not final or with non-zero position");

	// The reported count never exceeds the capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (CAPACITY < 32) |-> (m_tdata[8:4] <= 5'(CAPACITY)))
		else $error("entry count above capacity");

	// An input word is never taken while a held result still blocks the output.
	a_no_take_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input taken while output blocked");

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("stalled output word changed");

endmodule

bind ordered_list_store_core ols_checker #(.CAPACITY(CAPACITY)) u_ols_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the ordered list store core: list operation words in, result words out.
module testbench;

	localparam int Depth = 16;
	localparam int RandomOps = 330;
	localparam int DrainCycles = 3 * Depth + 20;
	localparam int CycleLimit = 1_500_000;

	typedef struct {
		ols_pkg::ols_op_t op;
		logic [31:0]      value;
	} list_op_t;

	typedef struct {
		ols_pkg::ols_status_t status;
		logic [3:0]           position;
		logic                 last;
		logic [4:0]           entry_count;
	} list_reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] value
	logic [1:0]  s_tuser = ols_pkg::OP_INSERT;   // [1:0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [3:0] position, [8:4] entry_count, [15:9] zero
	logic [1:0]  m_tuser;   // [1:0] status
	logic        m_tlast;

	list_op_t    queued_ops[$];
	list_reply_t pending_replies[$];

	// Shadow copy of the stored list, head at index zero.
	logic [31:0] shadow_list[Depth];
	int          shadow_len = 0;

	int  errors = 0;
	int  cycle_count = 0;
	logic op_taken = 1'b0;
	int  send_gap = 0;
	int  stall_left = 0;
	bit  send_calm = 1'b0;
	bit  recv_calm = 1'b0;

	ordered_list_store_core #(
		.CAPACITY(Depth)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic add_op(input ols_pkg::ols_op_t op, input logic [31:0] value);
		list_op_t item;
		item.op = op;
		item.value = value;
		queued_ops.push_back(item);
	endtask

	task automatic push_reply(input ols_pkg::ols_status_t status, input int position,
		input bit last);
		list_reply_t r;
		r.status = status;
		r.position = position[3:0];
		r.last = last;
		r.entry_count = shadow_len[4:0];
		pending_replies.push_back(r);
	endtask

	// Applies one accepted word to the shadow list and queues the replies it must cause.
	task automatic apply_list_op(input ols_pkg::ols_op_t op, input logic [31:0] key);
		int idx;
		int hits;
		case (op)
			ols_pkg::OP_INSERT: begin
				if (shadow_len >= Depth) begin
					push_reply(ols_pkg::ST_FULL, 0, 1'b1);
				end else begin
					shadow_list[shadow_len] = key;
					shadow_len++;
					push_reply(ols_pkg::ST_OK, 0, 1'b1);
				end
			end
			ols_pkg::OP_REMOVE: begin
				if (shadow_len == 0) begin
					push_reply(ols_pkg::ST_EMPTY, 0, 1'b1);
				end else begin
					// The match nearest the tail goes; later entries close the gap.
					idx = shadow_len - 1;
					while (idx >= 0 && shadow_list[idx] !== key)
						idx--;
					if (idx < 0) begin
						push_reply(ols_pkg::ST_NOT_FOUND, 0, 1'b1);
					end else begin
						for (int j = idx; j + 1 < shadow_len; j++)
							shadow_list[j] = shadow_list[j + 1];
						shadow_len--;
						push_reply(ols_pkg::ST_OK, idx, 1'b1);
					end
				end
			end
			ols_pkg::OP_SEARCH: begin
				idx = 0;
				while (idx < shadow_len && shadow_list[idx] !== key)
					idx++;
				if (idx < shadow_len)
					push_reply(ols_pkg::ST_OK, idx, 1'b1);
				else
					push_reply(ols_pkg::ST_NOT_FOUND, 0, 1'b1);
			end
			default: begin
				hits = 0;
				for (int j = 0; j < shadow_len && hits < ols_pkg::MaxResults; j++) begin
					if (shadow_list[j] === key) begin
						push_reply(ols_pkg::ST_OK, j, 1'b0);
						hits++;
					end
				end
				if (hits == 0)
					push_reply(ols_pkg::ST_NOT_FOUND, 0, 1'b1);
				else
					pending_replies[pending_replies.size() - 1].last = 1'b1;
			end
		endcase
	endtask

	// Mostly short gaps, now and then a long one; none at all during calm stretches.
	function automatic int draw_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(16, 40);
	endfunction

	// Input side: a new word is offered at the falling edge once the previous one has gone.
	always @(negedge clk) begin : op_driver
		list_op_t item;
		if (arst_n) begin
			if ($urandom_range(0, 149) == 0)
				send_calm = !send_calm;
			if (!s_tvalid || op_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (queued_ops.size() > 0) begin
					item = queued_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= item.op;
					s_tdata <= item.value;
					send_gap = draw_gap(send_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			op_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				apply_list_op(ols_pkg::ols_op_t'(s_tuser), s_tdata);
		end
	end

	// Output side: random back-pressure, decided at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 149) == 0)
				recv_calm = !recv_calm;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = draw_gap(recv_calm);
			end
		end
	end

	always @(posedge clk) begin : reply_monitor
		list_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				report_error($sformatf("unexpected result word tuser=%0d tdata=%h last=%b",
					m_tuser, m_tdata, m_tlast));
			end else begin
				want = pending_replies.pop_front();
				if (m_tuser !== want.status)
					report_error($sformatf("status %0d, expected %s", m_tuser, want.status.name()));
				if (m_tdata[3:0] !== want.position)
					report_error($sformatf("position %0d, expected %0d",
						m_tdata[3:0], want.position));
				if (m_tdata[8:4] !== want.entry_count)
					report_error($sformatf("entry count %0d, expected %0d",
						m_tdata[8:4], want.entry_count));
				if (m_tdata[15:9] !== 7'd0)
					report_error($sformatf("padding bits of tdata are %b", m_tdata[15:9]));
				if (m_tlast !== want.last)
					report_error($sformatf("tlast %b, expected %b", m_tlast, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] pool[6];
		bit grow;
		int burst;
		int r;
		ols_pkg::ols_op_t op;
		logic [31:0] value;

		arst_n = 1'b0;

		// Every operation on the empty list first.
		add_op(ols_pkg::OP_SEARCH, 32'h0000_0000);
		add_op(ols_pkg::OP_SEARCH_ALL, 32'h0000_0000);
		add_op(ols_pkg::OP_REMOVE, 32'h0000_0000);
		// Extreme and alternating bit patterns.
		add_op(ols_pkg::OP_INSERT, 32'h8000_0000);
		add_op(ols_pkg::OP_INSERT, 32'h7FFF_FFFF);
		add_op(ols_pkg::OP_INSERT, 32'h0000_0000);
		add_op(ols_pkg::OP_INSERT, 32'hFFFF_FFFF);
		add_op(ols_pkg::OP_INSERT, 32'h5555_5555);
		add_op(ols_pkg::OP_INSERT, 32'hAAAA_AAAA);
		add_op(ols_pkg::OP_SEARCH, 32'h7FFF_FFFF);
		add_op(ols_pkg::OP_SEARCH_ALL, 32'h1234_5678);
		add_op(ols_pkg::OP_REMOVE, 32'h1234_5678);
		// Duplicates: the first match is searched, the last one removed.
		add_op(ols_pkg::OP_INSERT, 32'hFFFF_FFFF);
		add_op(ols_pkg::OP_INSERT, 32'h8000_0000);
		add_op(ols_pkg::OP_SEARCH_ALL, 32'hFFFF_FFFF);
		add_op(ols_pkg::OP_SEARCH, 32'hFFFF_FFFF);
		add_op(ols_pkg::OP_REMOVE, 32'hFFFF_FFFF);
		add_op(ols_pkg::OP_SEARCH_ALL, 32'hFFFF_FFFF);
		// Fill the list with one value, overflow it, then report every match.
		repeat (10)
			add_op(ols_pkg::OP_INSERT, 32'h0000_0007);
		add_op(ols_pkg::OP_SEARCH_ALL, 32'h0000_0007);
		add_op(ols_pkg::OP_REMOVE, 32'h8000_0000);

		// Random part: grow and shrink bursts over a small pool of values so that
		// matches, duplicates, a full list and an empty list all come up often.
		pool[0] = 32'h0000_0000;
		pool[1] = 32'hFFFF_FFFF;
		pool[2] = 32'h8000_0000;
		pool[3] = 32'h7FFF_FFFF;
		pool[4] = $urandom;
		pool[5] = $urandom;
		grow = 1'b0;
		burst = 0;
		for (int n = 0; n < RandomOps; n++) begin
			if (burst == 0) begin
				grow = !grow;
				burst = $urandom_range(15, 45);
			end
			burst--;
			if ($urandom_range(0, 39) == 0)
				pool[$urandom_range(0, 5)] = $urandom;
			r = $urandom_range(0, 99);
			if (r < (grow ? 55 : 10))
				op = ols_pkg::OP_INSERT;
			else if (r < (grow ? 65 : 65))
				op = ols_pkg::OP_REMOVE;
			else if (r < 82)
				op = ols_pkg::OP_SEARCH;
			else
				op = ols_pkg::OP_SEARCH_ALL;
			if ($urandom_range(0, 9) < 8)
				value = pool[$urandom_range(0, 5)];
			else
				value = $urandom;
			add_op(op, value);
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (queued_ops.size() > 0 || s_tvalid)
			@(posedge clk);
		while (pending_replies.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (pending_replies.size() > 0)
			report_error($sformatf("%0d result words never arrived", pending_replies.size()));
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ols_pkg.sv
sv/ols_cell.sv
sv/ordered_list_store_core.sv
sv/ols_checker.sv
tb/testbench.sv
